// File: rtl/core/lkdc_pkg.sv
// Package for the ladder keypad debounce counter.
// Shared types, codes and reset constants; no dependencies.
package lkdc_pkg;

    localparam int NUM_KEYS_DEF = 5;
    localparam int NUM_THRESH   = 6;
    localparam int THRESH_W     = 12;
    localparam int DELAY_W      = 16;
    localparam int TIME_W       = 32;
    localparam int COUNT_W      = 8;
    localparam int IDX_W        = 3;
    localparam int CFG_IDX_W    = 3;

    localparam logic [THRESH_W-1:0] SAMPLE_LIMIT = 12'd1024;
    localparam logic [COUNT_W-1:0]  COUNT_MAX    = 8'd255;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 3'd6;

    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_READ   = 1'b1;

    typedef logic [NUM_THRESH-1:0][THRESH_W-1:0] thresh_arr_t;

    localparam thresh_arr_t THRESH_RST = {12'd700, 12'd800, 12'd903,
                                          12'd970, 12'd1002, 12'd1024};
    localparam logic [DELAY_W-1:0] DELAY_RST = 16'd10;

    typedef struct packed {
        thresh_arr_t         thresh;
        logic [DELAY_W-1:0]  delay;
    } cfg_t;

    typedef enum logic [1:0] {
        PH_RELEASED = 2'd0,
        PH_TIMING   = 2'd1,
        PH_HELD     = 2'd2
    } key_phase_t;

    typedef struct packed {
        logic sample_en;
        logic consume;
    } key_cmd_t;

endpackage

// File: rtl/core/lkdc_cfg.sv
// Configuration register file: six window thresholds and the debounce delay.
// Depends on lkdc_pkg.
module lkdc_cfg
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lkdc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lkdc_pkg::DELAY_W-1:0]   cfg_data,
    output lkdc_pkg::cfg_t                 cfg
);
    import lkdc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            for (int i = 0; i < NUM_THRESH; i++)
            begin
                if (cfg_index == CFG_IDX_W'(i))
                begin
                    cfg_next.thresh[i] = cfg_data[THRESH_W-1:0];
                end
            end
            if (cfg_index == CFG_DEBOUNCE)
            begin
                cfg_next.delay = cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.thresh <= THRESH_RST;
            cfg_reg.delay  <= DELAY_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: rtl/core/lkdc_key.sv
// One key: window compare, debounce phase, timestamp and saturating press count.
// Depends on lkdc_pkg.
module lkdc_key
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  lkdc_pkg::key_cmd_t            cmd,
    input  logic [lkdc_pkg::THRESH_W-1:0] hi,
    input  logic [lkdc_pkg::THRESH_W-1:0] lo,
    input  logic [lkdc_pkg::THRESH_W-1:0] sample,
    input  logic [lkdc_pkg::TIME_W-1:0]   now_time,
    input  logic [lkdc_pkg::DELAY_W-1:0]  delay,
    output logic                          has_press
);
    import lkdc_pkg::*;

    key_phase_t         phase_reg;
    key_phase_t         phase_next;
    logic [TIME_W-1:0]  stamp_reg;
    logic [TIME_W-1:0]  stamp_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               in_window;
    logic [TIME_W-1:0]  elapsed;

    assign in_window = (hi > sample) && (sample > lo);
    assign has_press = (count_reg != '0);
    assign elapsed   = now_time - stamp_reg;

    always_comb
    begin
        phase_next = phase_reg;
        stamp_next = stamp_reg;
        count_next = count_reg;
        if (cmd.sample_en)
        begin
            if (!in_window)
            begin
                phase_next = PH_RELEASED;
            end
            else
            begin
                case (phase_reg)
                    PH_RELEASED:
                    begin
                        // the timestamp restarts from now_time on entry to the timing phase
                        stamp_next = now_time;
                        phase_next = PH_TIMING;
                    end
                    PH_HELD:
                    begin
                        phase_next = PH_HELD;
                    end
                    default:
                    begin
                        if (elapsed > TIME_W'(delay))
                        begin
                            phase_next = PH_HELD;
                            if (count_reg != COUNT_MAX)
                            begin
                                count_next = count_reg + COUNT_W'(1);
                            end
                        end
                    end
                endcase
            end
        end
        else if (cmd.consume && has_press)
        begin
            count_next = count_reg - COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_RELEASED;
            count_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stamp_reg <= stamp_next;
    end

endmodule

// File: rtl/core/ladder_keypad_debounce_counter_top.sv
// Top level of the ladder keypad debounce counter.
// Depends on lkdc_pkg, lkdc_cfg and lkdc_key.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one request: action 0 is an
//   analog sample with its millisecond timestamp, action 1 reads one press
//   of key key_index. Output channel (out_valid / out_stall) returns
//   key_pressed for each read request only; sample requests give no result.
//   Configuration writes go over cfg_valid / cfg_ready with cfg_index and
//   cfg_data; cfg_ready is always high, so write only while the block is idle.
// Timing:
//   A request is registered at acceptance and processed from the request
//   register once it can advance; a read result is then registered in the
//   output register. One request per cycle is accepted, limited only
//   by the output register.
// Reset:
//   All keys released, press counts zero, thresholds and delay to defaults.
// Stall:
//   The output register holds its result. A read request waiting behind it
//   raises in_stall; sample requests keep flowing since they give no result.
module ladder_keypad_debounce_counter_top
#(
    parameter int NUM_KEYS = lkdc_pkg::NUM_KEYS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           action,
    input  logic [lkdc_pkg::THRESH_W-1:0]  sample,
    input  logic [lkdc_pkg::TIME_W-1:0]    now_time,
    input  logic [lkdc_pkg::IDX_W-1:0]     key_index,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           key_pressed,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lkdc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lkdc_pkg::DELAY_W-1:0]   cfg_data
);
    import lkdc_pkg::*;

    cfg_t                cfg;

    logic                req_valid_reg;
    logic                req_valid_next;
    logic                req_action_reg;
    logic [THRESH_W-1:0] req_sample_reg;
    logic [TIME_W-1:0]   req_time_reg;
    logic [IDX_W-1:0]    req_index_reg;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic                key_pressed_reg;
    logic                key_pressed_next;

    logic                in_take;
    logic                out_free;
    logic                req_adv;
    logic                sample_ok;
    logic [NUM_KEYS-1:0] has_press;
    logic [NUM_KEYS-1:0] key_sel;

    lkdc_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign out_free  = !out_valid_reg || !out_stall;
    assign req_adv   = req_valid_reg && ((req_action_reg == ACT_SAMPLE) || out_free);
    assign in_stall  = req_valid_reg && !req_adv;
    assign in_take   = in_valid && !in_stall;
    assign sample_ok = (req_sample_reg <= SAMPLE_LIMIT);

    generate
        for (genvar k = 0; k < NUM_KEYS; k++)
        begin : g_key
            logic [THRESH_W-1:0] hi;
            logic [THRESH_W-1:0] lo;
            key_cmd_t            cmd;

            if (k < NUM_THRESH)
            begin : g_hi
                assign hi = cfg.thresh[k];
            end
            else
            begin : g_hi0
                assign hi = '0;
            end

            if (k + 1 < NUM_THRESH)
            begin : g_lo
                assign lo = cfg.thresh[k+1];
            end
            else
            begin : g_lo0
                assign lo = '0;
            end

            assign key_sel[k]    = (req_index_reg == IDX_W'(k));
            assign cmd.sample_en = req_adv && (req_action_reg == ACT_SAMPLE) && sample_ok;
            assign cmd.consume   = req_adv && (req_action_reg == ACT_READ) && key_sel[k];

            lkdc_key u_key
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .cmd       (cmd),
                .hi        (hi),
                .lo        (lo),
                .sample    (req_sample_reg),
                .now_time  (req_time_reg),
                .delay     (cfg.delay),
                .has_press (has_press[k])
            );
        end
    endgenerate

    always_comb
    begin
        req_valid_next = req_valid_reg;
        if (in_take)
        begin
            req_valid_next = 1'b1;
        end
        else if (req_adv)
        begin
            req_valid_next = 1'b0;
        end

        out_valid_next   = out_valid_reg;
        key_pressed_next = key_pressed_reg;
        if (req_adv && (req_action_reg == ACT_READ))
        begin
            out_valid_next   = 1'b1;
            key_pressed_next = |(has_press & key_sel);
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            req_action_reg <= action;
            req_sample_reg <= sample;
            req_time_reg   <= now_time;
            req_index_reg  <= key_index;
        end
        key_pressed_reg <= key_pressed_next;
    end

    assign out_valid   = out_valid_reg;
    assign key_pressed = key_pressed_reg;

endmodule
